// ===== hw/rtl/rcm_pkg.sv =====
// Shared types and constants of the rectangle coordinate mapper.
// Used by rcm_lane, rcm_merge and rect_coordinate_mapper_core; no dependencies.
package rcm_pkg;

  // coordinate width of inputs and packed corner fields
  localparam int CB = 16;
  localparam int CORNER_W = 2 * CB;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W = 3;
  localparam int RES_W = 32;

  // lane datapath widths
  localparam int NW = CB + 3;      // offset coordinate, signed
  localparam int PW = NW + CB;     // magnitude times scale
  localparam int QW = PW + 1;      // rounded numerator, quotient
  localparam int VW = QW + 4;      // quotient plus offsets and mirror

  // lane register stages: offset, multiply, round, one per quotient bit, post
  localparam int STAGES = QW + 4;
  localparam int LANES = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TGT_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TGT_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIENT  = 3'd4;

  // orientation bits
  localparam int OR_MIRROR_X = 0;
  localparam int OR_MIRROR_Y = 1;
  localparam int OR_SWAP     = 2;

  localparam logic [CORNER_W-1:0] CORNER_ONE = {CB'(1), CB'(1)};

  typedef struct packed {
    logic back;
    logic rect;
  } tag_t;

endpackage

// ===== hw/rtl/rcm_lane.sv =====
// One axis lane: offset, scale by p/q with rounding, offset back and saturate.
// Depends on rcm_pkg; the quotient is formed by a pipelined restoring divider.
module rcm_lane (
  input  logic                                clk,
  input  logic [rcm_pkg::STAGES-1:0]          en,
  input  logic signed [rcm_pkg::CB-1:0]       coord,
  input  rcm_pkg::tag_t                       tag_in,
  input  logic signed [rcm_pkg::CB-1:0]       s0,
  input  logic signed [rcm_pkg::CB-1:0]       s1,
  input  logic signed [rcm_pkg::CB-1:0]       t0,
  input  logic signed [rcm_pkg::CB-1:0]       t1,
  input  logic                                mirror,
  output logic signed [rcm_pkg::RES_W-1:0]    result,
  output rcm_pkg::tag_t                       tag_out
);
  import rcm_pkg::*;

  localparam logic signed [VW-1:0] SMAX = VW'(32'sh7FFFFFFF);
  localparam logic signed [VW-1:0] SMIN = VW'(32'sh80000000);

  logic [CB-1:0] sw;
  logic [CB-1:0] tw;
  assign sw = CB'(s1 - s0);
  assign tw = CB'(t1 - t0);

  // offset stage
  logic signed [NW-1:0] n_c;
  logic [NW-1:0] mag0;
  logic          neg0;
  tag_t          tag0;

  always_comb begin
    if (tag_in.back) begin
      n_c = NW'(coord) - NW'(t0);
    end else if (mirror) begin
      n_c = NW'(s0) + NW'(s1) - NW'(coord) - NW'(s0);
    end else begin
      n_c = NW'(coord) - NW'(s0);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      neg0 <= n_c[NW-1];
      mag0 <= n_c[NW-1] ? NW'(-n_c) : NW'(n_c);
      tag0 <= tag_in;
    end
  end

  // multiply stage
  logic [PW-1:0] prod1;
  logic          neg1;
  tag_t          tag1;
  logic [CB-1:0] p0;
  assign p0 = tag0.back ? sw : tw;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      prod1 <= PW'(mag0) * PW'(p0);
      neg1  <= neg0;
      tag1  <= tag0;
    end
  end

  // rounding stage: add or take away half the divisor
  logic [CB-1:0] d1;
  logic [QW-1:0] h1;
  logic [QW-1:0] num_c;
  assign d1 = tag1.back ? tw : sw;
  assign h1 = QW'(d1 >> 1);

  always_comb begin
    if (!neg1) begin
      num_c = QW'(prod1) + h1;
    end else if (QW'(prod1) < h1) begin
      num_c = '0;
    end else begin
      num_c = QW'(prod1) - h1;
    end
  end

  logic [CB-1:0] drem [QW+1];
  logic [QW-1:0] dnum [QW+1];
  logic          dneg [QW+1];
  tag_t          dtag [QW+1];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      drem[0] <= '0;
      dnum[0] <= num_c;
      dneg[0] <= neg1;
      dtag[0] <= tag1;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [CB-1:0] dk;
    logic [CB:0]   r_sh;
    logic          ge;
    assign dk   = dtag[k].back ? tw : sw;
    assign r_sh = {drem[k], dnum[k][QW-1]};
    assign ge   = r_sh >= {1'b0, dk};

    always_ff @(posedge clk) begin
      if (en[3+k]) begin
        drem[k+1] <= ge ? CB'(r_sh - {1'b0, dk}) : CB'(r_sh);
        dnum[k+1] <= {dnum[k][QW-2:0], ge};
        dneg[k+1] <= dneg[k];
        dtag[k+1] <= dtag[k];
      end
    end
  end

  // post stage: sign, offset, mirror on the way back, saturate
  logic signed [VW-1:0] sq;
  logic signed [VW-1:0] v1;
  logic signed [VW-1:0] v2;
  logic signed [RES_W-1:0] sat_c;

  always_comb begin
    sq = VW'(signed'({1'b0, dnum[QW]}));
    if (dneg[QW]) begin
      sq = -sq;
    end
    v1 = (dtag[QW].back ? VW'(s0) : VW'(t0)) + sq;
    if (dtag[QW].back && mirror) begin
      v2 = VW'(s0) + VW'(s1) - v1;
    end else begin
      v2 = v1;
    end
    if (v2 > SMAX) begin
      sat_c = RES_W'(SMAX);
    end else if (v2 < SMIN) begin
      sat_c = RES_W'(SMIN);
    end else begin
      sat_c = RES_W'(v2);
    end
  end

  always_ff @(posedge clk) begin
    if (en[STAGES-1]) begin
      result  <= sat_c;
      tag_out <= dtag[QW];
    end
  end

endmodule

// ===== hw/rtl/rcm_merge.sv =====
// Merge stage: swap axes back, order rectangle corners, zero on error.
// Depends on rcm_pkg; holds the output payload register.
module rcm_merge (
  input  logic                               clk,
  input  logic                               load,
  input  logic signed [rcm_pkg::RES_W-1:0]   lane_fx,
  input  logic signed [rcm_pkg::RES_W-1:0]   lane_fy,
  input  logic signed [rcm_pkg::RES_W-1:0]   lane_sx,
  input  logic signed [rcm_pkg::RES_W-1:0]   lane_sy,
  input  rcm_pkg::tag_t                      tag,
  input  logic                               swap,
  input  logic                               err,
  output logic signed [rcm_pkg::RES_W-1:0]   result_first_x,
  output logic signed [rcm_pkg::RES_W-1:0]   result_first_y,
  output logic signed [rcm_pkg::RES_W-1:0]   result_second_x,
  output logic signed [rcm_pkg::RES_W-1:0]   result_second_y,
  output logic                               empty_rect_error
);
  import rcm_pkg::*;

  logic signed [RES_W-1:0] ax, ay, bx, by;
  logic signed [RES_W-1:0] fx, fy, sx, sy;

  always_comb begin
    if (tag.back && swap) begin
      ax = lane_fy; ay = lane_fx; bx = lane_sy; by = lane_sx;
    end else begin
      ax = lane_fx; ay = lane_fy; bx = lane_sx; by = lane_sy;
    end
    fx = ax; fy = ay; sx = bx; sy = by;
    if (!tag.rect) begin
      sx = '0; sy = '0;
    end else begin
      if (ax >= bx) begin
        fx = bx; sx = ax;
      end
      if (ay >= by) begin
        fy = by; sy = ay;
      end
    end
    if (err) begin
      fx = '0; fy = '0; sx = '0; sy = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_first_x   <= fx;
      result_first_y   <= fy;
      result_second_x  <= sx;
      result_second_y  <= sy;
      empty_rect_error <= err;
    end
  end

endmodule

// ===== hw/rtl/rect_coordinate_mapper_core.sv =====
// Rectangle coordinate mapper: four lanes (two axes, two corners) plus a merge register.
// Stages: offset, multiply, round, one per quotient bit, post, then the merge register.
// Throughput: one item per cycle unless the output is stalled by out_ready.
// Bubbles collapse: input is taken while a finished item waits if any stage is empty.
// Reset (rst, synchronous): clears all stage valids and loads the register defaults.
// Depends on rcm_pkg, rcm_lane and rcm_merge.
module rect_coordinate_mapper_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         opcode,
  input  logic signed [rcm_pkg::CB-1:0]      first_x,
  input  logic signed [rcm_pkg::CB-1:0]      first_y,
  input  logic signed [rcm_pkg::CB-1:0]      second_x,
  input  logic signed [rcm_pkg::CB-1:0]      second_y,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [rcm_pkg::RES_W-1:0]   result_first_x,
  output logic signed [rcm_pkg::RES_W-1:0]   result_first_y,
  output logic signed [rcm_pkg::RES_W-1:0]   result_second_x,
  output logic signed [rcm_pkg::RES_W-1:0]   result_second_y,
  output logic                               empty_rect_error,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rcm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rcm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import rcm_pkg::*;

  // configuration registers
  logic [CORNER_W-1:0] src_min, src_max, tgt_min, tgt_max;
  logic [2:0]          orient;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_min <= '0;
      src_max <= CORNER_ONE;
      tgt_min <= '0;
      tgt_max <= CORNER_ONE;
      orient  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SRC_MIN: src_min <= cfg_data[CORNER_W-1:0];
        REG_SRC_MAX: src_max <= cfg_data[CORNER_W-1:0];
        REG_TGT_MIN: tgt_min <= cfg_data[CORNER_W-1:0];
        REG_TGT_MAX: tgt_max <= cfg_data[CORNER_W-1:0];
        REG_ORIENT:  orient  <= cfg_data[2:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // unpack corners
  logic signed [CB-1:0] sx0, sy0, sx1, sy1, tx0, ty0, tx1, ty1;
  assign sx0 = src_min[CB-1:0];
  assign sy0 = src_min[CORNER_W-1:CB];
  assign sx1 = src_max[CB-1:0];
  assign sy1 = src_max[CORNER_W-1:CB];
  assign tx0 = tgt_min[CB-1:0];
  assign ty0 = tgt_min[CORNER_W-1:CB];
  assign tx1 = tgt_max[CB-1:0];
  assign ty1 = tgt_max[CORNER_W-1:CB];

  logic swap;
  logic err;
  assign swap = orient[OR_SWAP];
  assign err  = (sx0 >= sx1) || (sy0 >= sy1) || (tx0 >= tx1) || (ty0 >= ty1);

  // source rectangle as seen in the swapped frame
  logic signed [CB-1:0] fx0, fx1, fy0, fy1;
  assign fx0 = swap ? sy0 : sx0;
  assign fx1 = swap ? sy1 : sx1;
  assign fy0 = swap ? sx0 : sy0;
  assign fy1 = swap ? sx1 : sy1;

  // stage valids; a stage loads when empty or when the next one moves
  logic [STAGES-1:0] vld;
  logic [STAGES:0]   go;

  always_comb begin
    go[STAGES] = !out_valid || out_ready;
    for (int i = STAGES - 1; i >= 0; i--) begin
      go[i] = !vld[i] || go[i+1];
    end
  end

  assign in_ready = go[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (go[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (go[i]) begin
          vld[i] <= vld[i-1];
        end
      end
      if (go[STAGES]) begin
        out_valid <= vld[STAGES-1];
      end
    end
  end

  // forward map swaps the input point before scaling
  tag_t tag_in;
  logic in_swap;
  assign tag_in.back = opcode[0];
  assign tag_in.rect = opcode[1];
  assign in_swap = swap && !opcode[0];

  logic signed [CB-1:0] lane_in [LANES];
  assign lane_in[0] = in_swap ? first_y  : first_x;
  assign lane_in[1] = in_swap ? first_x  : first_y;
  assign lane_in[2] = in_swap ? second_y : second_x;
  assign lane_in[3] = in_swap ? second_x : second_y;

  logic signed [RES_W-1:0] lane_res [LANES];
  tag_t                    lane_tag [LANES];

  // even lanes carry x, odd lanes carry y
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    logic is_y;
    assign is_y = (g % 2) == 1;
    rcm_lane u_lane (
      .clk     (clk),
      .en      (go[STAGES-1:0]),
      .coord   (lane_in[g]),
      .tag_in  (tag_in),
      .s0      (is_y ? fy0 : fx0),
      .s1      (is_y ? fy1 : fx1),
      .t0      (is_y ? ty0 : tx0),
      .t1      (is_y ? ty1 : tx1),
      .mirror  (is_y ? orient[OR_MIRROR_Y] : orient[OR_MIRROR_X]),
      .result  (lane_res[g]),
      .tag_out (lane_tag[g])
    );
  end

  rcm_merge u_merge (
    .clk              (clk),
    .load             (go[STAGES]),
    .lane_fx          (lane_res[0]),
    .lane_fy          (lane_res[1]),
    .lane_sx          (lane_res[2]),
    .lane_sy          (lane_res[3]),
    .tag              (lane_tag[0]),
    .swap             (swap),
    .err              (err),
    .result_first_x   (result_first_x),
    .result_first_y   (result_first_y),
    .result_second_x  (result_second_x),
    .result_second_y  (result_second_y),
    .empty_rect_error (empty_rect_error)
  );

endmodule
